// ===== hdl/h3fpp_pkg.sv =====
`default_nettype none

package h3fpp_pkg;

   localparam int VarintWidth = 62;

   // Input opcodes
   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_EOS   = 2'd1,
      OP_REARM = 2'd2
   } opcode_type;

   // Parser phase
   typedef enum logic [1:0] {
      PH_TYPE   = 2'd0,
      PH_LEN    = 2'd1,
      PH_READY  = 2'd2,
      PH_FAILED = 2'd3
   } phase_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_NEED       = 3'd0,
      ST_OK         = 3'd1,
      ST_EXCESS     = 3'd2,
      ST_EOF        = 3'd3,
      ST_TRUNC_TYPE = 3'd4,
      ST_NO_LEN     = 3'd5,
      ST_TRUNC_LEN  = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] byte_value;
   } item_type;

   typedef struct packed {
      status_type             status;
      logic                   consumed;
      logic [VarintWidth-1:0] frame_kind;
      logic [VarintWidth-1:0] body_length;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/h3fpp_in_reg.sv =====
`default_nettype none

module h3fpp_in_reg (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire h3fpp_pkg::item_type req_item,
   input  wire                 advance,
   output logic                req_stall,
   output logic                item_valid,
   output h3fpp_pkg::item_type item
);
   import h3fpp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   // Stall while a held transaction cannot move on
   assign req_stall = valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hdl/h3fpp_core.sv =====
`default_nettype none

module h3fpp_core (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write,
   input  wire  [h3fpp_pkg::VarintWidth-1:0]     csr_data,
   input  wire                                   advance,
   input  wire  h3fpp_pkg::item_type             item,
   output h3fpp_pkg::result_type                 result
);
   import h3fpp_pkg::*;

   logic [VarintWidth-1:0] max_payload_ff;
   phase_type              phase_ff, phase_in;
   status_type             failure_ff, failure_in;
   logic [3:0]             have_ff, have_in;
   logic [3:0]             need_ff, need_in;
   logic [VarintWidth-1:0] accum_ff, accum_in;
   logic [VarintWidth-1:0] held_type_ff, held_type_in;
   logic [VarintWidth-1:0] held_length_ff, held_length_in;

   logic                   first_byte;
   logic [VarintWidth-1:0] acc_next;
   logic [3:0]             have_next;
   logic [3:0]             need_next;
   logic                   varint_done;
   status_type             idle_status;
   status_type             status;
   logic                   consumed;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= '1;
      end else if (csr_write) begin
         max_payload_ff <= csr_data;
      end
   end

   // Varint byte assembly
   assign first_byte = (have_ff == 4'd0);
   assign acc_next   = first_byte ? {{(VarintWidth-6){1'b0}}, item.byte_value[5:0]}
                                  : {accum_ff[VarintWidth-9:0], item.byte_value};
   assign have_next  = first_byte ? 4'd1 : have_ff + 4'd1;
   assign need_next  = first_byte ? (4'd1 << item.byte_value[7:6]) : need_ff;
   assign varint_done = (have_next == need_next);

   always_comb begin
      case (phase_ff)
         PH_FAILED: idle_status = failure_ff;
         PH_READY:  idle_status = ST_OK;
         default:   idle_status = ST_NEED;
      endcase
   end

   // Next state and status
   always_comb begin
      phase_in       = phase_ff;
      failure_in     = failure_ff;
      have_in        = have_ff;
      need_in        = need_ff;
      accum_in       = accum_ff;
      held_type_in   = held_type_ff;
      held_length_in = held_length_ff;
      status         = idle_status;
      consumed       = 1'b0;
      case (item.opcode)
         OP_BYTE: begin
            if (phase_ff == PH_TYPE || phase_ff == PH_LEN) begin
               consumed = 1'b1;
               status   = ST_NEED;
               if (!varint_done) begin
                  have_in  = have_next;
                  need_in  = need_next;
                  accum_in = acc_next;
               end else begin
                  have_in  = 4'd0;
                  need_in  = 4'd0;
                  accum_in = '0;
                  if (phase_ff == PH_TYPE) begin
                     held_type_in = acc_next;
                     phase_in     = PH_LEN;
                  end else if (acc_next > max_payload_ff) begin
                     phase_in   = PH_FAILED;
                     failure_in = ST_EXCESS;
                     status     = ST_EXCESS;
                  end else begin
                     held_length_in = acc_next;
                     phase_in       = PH_READY;
                     status         = ST_OK;
                  end
               end
            end
         end
         OP_EOS: begin
            if (phase_ff == PH_TYPE) begin
               if (first_byte) begin
                  status = ST_EOF;
               end else begin
                  phase_in   = PH_FAILED;
                  failure_in = ST_TRUNC_TYPE;
                  status     = ST_TRUNC_TYPE;
               end
            end else if (phase_ff == PH_LEN) begin
               phase_in   = PH_FAILED;
               failure_in = first_byte ? ST_NO_LEN : ST_TRUNC_LEN;
               status     = first_byte ? ST_NO_LEN : ST_TRUNC_LEN;
            end
         end
         OP_REARM: begin
            phase_in       = PH_TYPE;
            failure_in     = ST_NEED;
            have_in        = 4'd0;
            need_in        = 4'd0;
            accum_in       = '0;
            held_type_in   = '0;
            held_length_in = '0;
            status         = ST_NEED;
         end
         default: begin
            status = idle_status;
         end
      endcase
   end

   // State register, updated once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TYPE;
         failure_ff     <= ST_NEED;
         have_ff        <= 4'd0;
         need_ff        <= 4'd0;
         accum_ff       <= '0;
         held_type_ff   <= '0;
         held_length_ff <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         failure_ff     <= failure_in;
         have_ff        <= have_in;
         need_ff        <= need_in;
         accum_ff       <= accum_in;
         held_type_ff   <= held_type_in;
         held_length_ff <= held_length_in;
      end
   end

   // Report held values only with ok
   always_comb begin
      result.status      = status;
      result.consumed    = consumed;
      result.frame_kind  = (status == ST_OK) ? held_type_in : '0;
      result.body_length = (status == ST_OK) ? held_length_in : '0;
   end

endmodule

`default_nettype wire

// ===== hdl/h3fpp_out_reg.sv =====
`default_nettype none

module h3fpp_out_reg (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          item_valid,
   input  wire  h3fpp_pkg::result_type  result,
   input  wire                          rsp_stall,
   output logic                         advance,
   output logic                         rsp_valid,
   output h3fpp_pkg::result_type        rsp_result
);
   import h3fpp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // Advance when the result slot is empty or being drained
   assign advance  = item_valid & (~valid_ff | ~rsp_stall);
   assign valid_in = advance | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load result
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== hdl/http3_frame_prefix_parser.sv =====
// Two register stages: input register, result register.
// Throughput: one transaction per cycle while rsp_stall is low; parser state updates
//   in the same cycle the result is loaded.
// Reset (synchronous, active high): parser clears, max_payload returns to 2^62-1.
`default_nettype none

module http3_frame_prefix_parser (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [1:0]   req_opcode,
   input  wire  [7:0]   req_byte_value,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [2:0]   rsp_status,
   output logic         rsp_consumed,
   output logic [61:0]  rsp_frame_kind,
   output logic [61:0]  rsp_body_length,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [61:0]  csr_max_payload
);
   import h3fpp_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   result_type result;
   result_type rsp_result;

   assign req_item.opcode     = req_opcode;
   assign req_item.byte_value = req_byte_value;
   assign csr_ready           = 1'b1;

   h3fpp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .advance    (advance),
      .req_stall  (req_stall),
      .item_valid (item_valid),
      .item       (item)
   );

   h3fpp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_max_payload),
      .advance   (advance),
      .item      (item),
      .result    (result)
   );

   h3fpp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_status      = rsp_result.status;
   assign rsp_consumed    = rsp_result.consumed;
   assign rsp_frame_kind  = rsp_result.frame_kind;
   assign rsp_body_length = rsp_result.body_length;

   // A consumed byte only ever yields need input, ok or excessive load
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_consumed) |->
         (rsp_status == ST_NEED || rsp_status == ST_OK || rsp_status == ST_EXCESS))
      else $error("consumed byte with unexpected status");

   // Held values are reported only with ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_frame_kind == '0 && rsp_body_length == '0))
      else $error("held values leaked on non-ok status");

   // The input side never stalls while the result side drains freely
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled with free result side");

endmodule

`default_nettype wire
